// ===== rtl/bitmap_run_allocator_core_assert.svh =====
// assertion macros shared by the allocator rtl
`ifndef BITMAP_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define BRA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define BRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BRA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/bra_pkg.sv =====
// shared types, constants and helpers of the bitmap run allocator
`default_nettype none

package bra_pkg;

  // default configuration
  localparam int MAP_BITS_DEF = 4096;
  localparam int MAX_RUN_DEF  = 16;

  // map word geometry
  localparam int WORD_BITS = 64;
  localparam int JW        = 6;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one queued request
  typedef struct packed {
    logic [4:0] run_length;
    logic       reject;
  } req_t;

  // index of the lowest set bit of a map word window
  function automatic logic [JW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [JW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = JW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bra_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module bra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bra_front.sv =====
// request front end: accepts, classifies and queues run requests
`default_nettype none

`include "bitmap_run_allocator_core_assert.svh"

module bra_front #(
  parameter int MAX_RUN = bra_pkg::MAX_RUN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [4:0]    in_run_length,
  output logic               q_valid,
  output bra_pkg::req_t      q_req,
  input  wire logic          q_pop
);

  localparam int QD  = bra_pkg::QUEUE_DEPTH;
  localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  bra_pkg::req_t  q_r [QD];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push;
  bra_pkg::req_t  push_req;

  // zero length and over-long requests are refused without a scan
  always_comb begin
    push_req.run_length = in_run_length;
    push_req.reject     = (in_run_length == 5'd0) ||
                          (int'({27'd0, in_run_length}) > MAX_RUN);
  end

  assign busy    = (count_r == QCW'(QD));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_req   = q_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QD - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QD - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !q_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_req;
    end
  end

  `BRA_ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && (count_r == '0), "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/bra_back.sv =====
// scan engine: walks the free map word by word and claims the first run
`default_nettype none

`include "bitmap_run_allocator_core_assert.svh"

module bra_back #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire bra_pkg::req_t q_req,
  output logic               q_pop,
  input  wire logic [31:0]   first_sector,
  output logic               out_strobe,
  output logic               out_found,
  output logic [31:0]        out_start_sector
);

  localparam int WB        = bra_pkg::WORD_BITS;
  localparam int JW        = bra_pkg::JW;
  localparam int MAP_WORDS = (MAP_BITS + WB - 1) / WB;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = AW + JW;
  localparam int TAIL_BITS = MAP_BITS % WB;
  localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);
  // bits past the end of the map in the last word count as used
  localparam logic [WB-1:0] TAIL_MASK =
    (TAIL_BITS == 0) ? '0 : ~((WB'(1) << TAIL_BITS) - WB'(1));

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_WR_CUR  = 2'd2;
  localparam logic [1:0] ST_WR_PREV = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        w_r, w_nxt;
  logic [4:0]           len_r, len_nxt;
  logic [WB-1:0]        prev_r, prev_nxt;
  logic [WB-1:0]        cur_r, cur_nxt;
  logic [JW-1:0]        hit_j_r, hit_j_nxt;
  logic [MAP_WORDS-1:0] valid_r;
  logic                 valid_q_r;
  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [31:0]          out_start_r, out_start_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WB-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WB-1:0]        ram_rdata;

  logic [WB-1:0]        cur_word;
  logic [2*WB-1:0]      window;
  logic [WB-1:0]        top_mask;
  logic [WB-1:0]        hit_vec;
  logic                 any_hit;
  logic [JW-1:0]        hit_j;
  logic [7:0]           claim_shift;
  logic [2*WB-1:0]      claim;
  logic                 need_prev;
  logic [IW-1:0]        start_idx;
  logic [31:0]          start_sum;

  bra_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // current word, never-written words read as free
  assign cur_word = (valid_q_r ? ram_rdata : '0) | ((w_r == LAST_W) ? TAIL_MASK : '0);
  assign window   = {cur_word, prev_r};
  assign top_mask = ~({WB{1'b1}} >> len_r);

  // a run of len_r clear bits ends at bit j of the current word
  for (genvar j = 0; j < WB; j++) begin : g_hit
    assign hit_vec[j] = ((window[j+1 +: WB] & top_mask) == '0);
  end

  assign any_hit = |hit_vec;
  assign hit_j   = bra_pkg::lowest_set(hit_vec);

  // claimed bits across previous and current word
  assign claim_shift = 8'd65 + {2'b00, hit_j_r} - {3'b000, len_r};
  assign claim       = (((2*WB)'(1) << len_r) - (2*WB)'(1)) << claim_shift;
  assign need_prev   = |claim[WB-1:0];

  // start index and base sum
  assign start_idx = {w_r, hit_j_r} + IW'(1) - IW'(len_r);
  assign start_sum = 32'(start_idx) + first_sector;

  // read address follows the scan one word ahead
  assign ram_raddr = (state_r == ST_SCAN && w_r != LAST_W) ? w_r + AW'(1) :
                     (state_r == ST_SCAN) ? w_r : '0;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    len_nxt        = len_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    hit_j_nxt      = hit_j_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = out_found_r;
    out_start_nxt  = out_start_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = cur_r | claim[2*WB-1:WB];
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_req.reject) begin
            out_strobe_nxt = 1'b1;
            out_found_nxt  = 1'b0;
            out_start_nxt  = '0;
          end else begin
            len_nxt   = q_req.run_length;
            w_nxt     = '0;
            prev_nxt  = '1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (any_hit) begin
          hit_j_nxt = hit_j;
          cur_nxt   = cur_word;
          state_nxt = ST_WR_CUR;
        end else if (w_r == LAST_W) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b0;
          out_start_nxt  = '0;
          state_nxt      = ST_IDLE;
        end else begin
          prev_nxt = cur_word;
          w_nxt    = w_r + AW'(1);
        end
      end
      ST_WR_CUR: begin
        ram_we = 1'b1;
        if (need_prev) begin
          state_nxt = ST_WR_PREV;
        end else begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          out_start_nxt  = start_sum;
          state_nxt      = ST_IDLE;
        end
      end
      ST_WR_PREV: begin
        ram_we         = 1'b1;
        ram_waddr      = w_r - AW'(1);
        ram_wdata      = prev_r | claim[WB-1:0];
        out_strobe_nxt = 1'b1;
        out_found_nxt  = 1'b1;
        out_start_nxt  = start_sum;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers and word valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
      valid_q_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      valid_q_r    <= valid_r[ram_raddr];
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    len_r       <= len_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    hit_j_r     <= hit_j_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_found        = out_found_r;
  assign out_start_sector = out_start_r;

  `BRA_ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_strobe_r, state_r == ST_IDLE, "result beat outside idle")
  `BRA_ASSERT_IMPL(a_we_state, clk, rst_n, ram_we, (state_r == ST_WR_CUR) || (state_r == ST_WR_PREV), "map write outside write-back")
  `BRA_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_strobe_r && !out_found_r, out_start_r == 32'd0, "miss with nonzero sector")
  `BRA_ASSERT_NEVER(a_prev_word0, clk, rst_n, (state_r == ST_WR_PREV) && (w_r == '0), "write-back before word zero")

endmodule

`default_nettype wire

// ===== rtl/bitmap_run_allocator_core.sv =====
// top level of the first-fit contiguous run allocator
//
// usage:
//   a request is taken on a clock edge with start high and busy low; in_run_length
//   gives the number of consecutive free sectors wanted. busy is high while the
//   two-entry request queue is full.
//   each request yields one result beat: out_strobe is high for one cycle with
//   out_found and out_start_sector (first claimed bit index plus first_sector,
//   modulo 2^32, or zero on a miss). results leave in request order.
//   cfg_we/cfg_wdata load first_sector; write it only while no request is pending.
// timing:
//   the back end reads one 64-bit map word per cycle. a request passes through the queue and
//   dispatch, the word scan up to the word in which its run ends, write-back of that word
//   (and of the word before it when the run starts there) and the output register.
//   a miss scans every map word; a refused length (zero or above MAX_RUN) skips the scan
//   and write-back. requests are served one at a time.
// reset:
//   synchronous reset marks every map word free through per-word valid bits,
//   clears first_sector and empties the queue; no clearing pass is needed.
//   the receiver cannot stall; each result beat is taken in its one cycle.
`default_nettype none

module bitmap_run_allocator_core #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF,
  parameter int MAX_RUN  = bra_pkg::MAX_RUN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  in_run_length,
  output logic             out_strobe,
  output logic             out_found,
  output logic [31:0]      out_start_sector,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  logic          q_valid;
  bra_pkg::req_t q_req;
  logic          q_pop;
  logic [31:0]   first_sector_r;

  // base sector register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sector_r <= '0;
    end else if (cfg_we) begin
      first_sector_r <= cfg_wdata;
    end
  end

  // accept and classify
  bra_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_run_length (in_run_length),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  // scan and claim
  bra_back #(
    .MAP_BITS (MAP_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop),
    .first_sector     (first_sector_r),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_start_sector (out_start_sector)
  );

endmodule

`default_nettype wire
